>>> rtl/core/newton_square_root_defines.svh
// ----------------------------------------------------------------------------
// newton_square_root_defines.svh
// Assertion macros shared by the square root core.
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsr same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsr next-cycle check failed");

`endif

>>> rtl/core/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Types and fixed constants of the Newton-Raphson square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int X_W     = 32;   // operand and estimate width
    localparam int ROOT_W  = 25;   // result root width
    localparam int COUNT_W = 6;    // result iteration count width
    localparam int TOL_W   = 16;   // tolerance register width
    localparam int DATA_W  = 32;   // APB data width
    localparam int ADDR_W  = 3;    // APB byte address width
    localparam int IDX_W   = ADDR_W - 2;

    localparam logic [IDX_W-1:0] IDX_TOLERANCE = '0;
    localparam logic [TOL_W-1:0] TOL_RESET     = TOL_W'(1);

    localparam logic [ROOT_W-1:0]  ROOT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } nsr_state_t;

endpackage

>>> rtl/core/nsr_divider.sv
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_divider
    import nsr_pkg::*;
#(
    parameter int NUM_W = 48
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [X_W-1:0]   divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [X_W-1:0]   rem_reg, rem_next;
    logic [X_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [X_W:0] rem_shift;
    logic [X_W:0] trial;
    logic         fits;

    // Bring down the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign trial     = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? trial[X_W-1:0] : rem_shift[X_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// Newton-Raphson square root of an unsigned fixed-point operand.
// ----------------------------------------------------------------------------
// Takes one unsigned operand x_value with FRAC_BITS fraction bits (Q16.16 by
// default) and returns its square root in the same format. The estimate starts
// at the larger of x and 1.0; each iteration replaces it with the floor of
// (y + floor(x * 2^FRAC_BITS / y)) / 2, and iteration ends once two successive
// estimates differ by no more than the tolerance register (APB byte address 0,
// low 16 bits, reset 1), or after MAX_ITERATIONS iterations, in which case
// cap_reached is set. The root saturates at 2^25 - 1 and iterations_used at 63.
// One shared restoring divider of 32 + FRAC_BITS quotient bits does all the
// divisions, one bit per cycle; each iteration is a check state followed by
// the divide state. A typical Q16.16 operand needs about 5 to 20
// iterations.
// in_ready is high only while the core is idle; a finished word waits in the
// output register, so the next operand can be taken while it is unclaimed.
// ----------------------------------------------------------------------------
`include "newton_square_root_defines.svh"

module newton_square_root
    import nsr_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int MAX_ITERATIONS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,

    // operand channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [X_W-1:0]     x_value,

    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ROOT_W-1:0]  root,
    output logic [COUNT_W-1:0] iterations_used,
    output logic               cap_reached
);

    localparam int NUM_W = X_W + FRAC_BITS;              // width of x << FRAC_BITS
    localparam int IT_W  = $clog2(MAX_ITERATIONS + 1);   // iteration counter width
    // reported iteration count when the cap stops iteration
    localparam int CAP_COUNT = (MAX_ITERATIONS > int'(COUNT_MAX)) ?
                               int'(COUNT_MAX) : MAX_ITERATIONS;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [TOL_W-1:0] tol_reg;
    logic             cfg_write;
    logic             cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[ADDR_W-1:2] == IDX_TOLERANCE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {{(DATA_W-TOL_W){1'b0}}, tol_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write && cfg_hit)
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    nsr_state_t state_reg, state_next;

    logic [X_W-1:0]  x_reg;
    logic [X_W-1:0]  y_reg;
    logic [X_W-1:0]  z_reg;
    logic [IT_W-1:0] iters_reg;
    logic            cap_reg;

    logic             out_valid_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [COUNT_W-1:0] count_reg;
    logic             cap_out_reg;

    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    logic            accept;
    logic            load_out;
    logic [X_W-1:0]  diff;
    logic            not_settled;
    logic            at_cap;
    logic [NUM_W:0]  sum;
    logic [NUM_W-1:0] q_safe;
    logic [X_W-1:0]  y_start;
    logic [X_W-1:0]  one_fx;
    logic [IT_W+COUNT_W-1:0] iters_ext;

    assign accept = in_valid && in_ready;

    // 1.0 in the operand format
    assign one_fx  = X_W'(1) << FRAC_BITS;
    assign y_start = (x_value < one_fx) ? one_fx : x_value;

    // Convergence test on the two latest estimates.
    assign diff        = (y_reg >= z_reg) ? (y_reg - z_reg) : (z_reg - y_reg);
    assign not_settled = diff > {{(X_W-TOL_W){1'b0}}, tol_reg};
    assign at_cap      = iters_reg >= IT_W'(MAX_ITERATIONS);

    // Division by zero only arises for a zero operand: take the quotient as 0.
    // The estimate never outgrows X_W bits, so the top of the sum is dropped.
    assign q_safe = (z_reg == '0) ? '0 : div_quo;
    assign sum    = {{(NUM_W-X_W+1){1'b0}}, z_reg} + {1'b0, q_safe};

    assign iters_ext = {{COUNT_W{1'b0}}, iters_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!not_settled || at_cap)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CHECK:
            begin
                div_start = not_settled && !at_cap;
            end
            S_DIV:
            begin
            end
            S_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iters_reg <= '0;
            cap_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                iters_reg <= '0;
                cap_reg   <= 1'b0;
            end
            else if (state_reg == S_CHECK)
            begin
                if (div_start)
                begin
                    iters_reg <= iters_reg + IT_W'(1);
                end
                // another step wanted but the budget is spent
                cap_reg <= not_settled && at_cap;
            end
        end
    end

    // Estimate registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= x_value;
            y_reg <= y_start;
            z_reg <= '0;
        end
        else if (div_start)
        begin
            z_reg <= y_reg;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            y_reg <= sum[X_W:1];
        end
    end

    // Shared divider: (x << FRAC_BITS) / z
    nsr_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({x_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (y_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Output register: hold the word until it is taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            root_reg    <= (y_reg > X_W'(ROOT_MAX)) ? ROOT_MAX : y_reg[ROOT_W-1:0];
            count_reg   <= (iters_ext > (IT_W+COUNT_W)'(COUNT_MAX)) ?
                           COUNT_MAX : iters_ext[COUNT_W-1:0];
            cap_out_reg <= cap_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign root            = root_reg;
    assign iterations_used = count_reg;
    assign cap_reached     = cap_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NSR_ASSERT_NEXT(a_accept_starts_check, accept, state_reg == S_CHECK)
    `NSR_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == S_DIV)
    `NSR_ASSERT_NOW(a_iters_in_budget, 1'b1, iters_reg <= IT_W'(MAX_ITERATIONS))
    `NSR_ASSERT_NOW(a_cap_full_count, out_valid_reg && cap_out_reg, count_reg == COUNT_W'(CAP_COUNT))

endmodule

>>> tb/newton_square_root_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// newton_square_root_test
// Self-checking bench for the Newton-Raphson square root core.
// ----------------------------------------------------------------------------
// Each Q16.16 operand goes through the valid/ready operand channel. The
// expected root, iteration count and cap flag are worked out by a bench-side
// Newton iteration in 64-bit arithmetic (or given in the directed table), and every result
// word is compared field by field, in order. The tolerance register is set
// over APB only while the core is idle, and each value is read back. A short
// table of directed operands comes first. Six random segments follow, each
// with its own tolerance; the idle pattern is shared by pairs of segments.
// ----------------------------------------------------------------------------
module newton_square_root_test;
    import nsr_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_ITERATIONS = 32;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_WORDS  = 195;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 120;
    // Slowest correct run: about 1200 operands, each up to 32 iterations,
    // plus long result stalls. Allow several times that.
    localparam longint CYCLE_LIMIT = 10_000_000;

    localparam logic [ADDR_W-1:0] TOL_ADDR = {IDX_TOLERANCE, 2'b00};

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [COUNT_W-1:0] iters;
        logic               cap;
    } sqrt_word_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        sqrt_word_t     want;
    } pending_t;

    typedef struct packed {
        logic [DATA_W-1:0] tol_write;
        logic [X_W-1:0]    x;
        logic              known;
        sqrt_word_t        want;
    } sqrt_case_t;

    // Drive every input of the core to a known value from time zero.
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [X_W-1:0]     x_value   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ROOT_W-1:0]  root;
    logic [COUNT_W-1:0] iterations_used;
    logic               cap_reached;

    pending_t          pending_roots[$];
    sqrt_case_t        sqrt_cases[$];
    logic [TOL_W-1:0]  tol_shadow = TOL_RESET;
    logic [DATA_W-1:0] tol_raw    = DATA_W'(TOL_RESET);
    int                mismatch_count = 0;
    int                send_idle_pct  = 0;
    int                recv_idle_pct  = 0;
    longint            cycle_count    = 0;

    newton_square_root #(
        .FRAC_BITS      (FRAC_BITS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .x_value         (x_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .root            (root),
        .iterations_used (iterations_used),
        .cap_reached     (cap_reached)
    );

    always #6 clk = ~clk;

    // Bound the run: a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Run the Newton iteration in 64-bit arithmetic. The previous estimate
    // starts at zero, the current one at max(x, 1.0); a zero divisor gives a
    // zero quotient. Saturate root and count to their field widths.
    function automatic sqrt_word_t predict_sqrt(input logic [X_W-1:0] x,
                                                input logic [TOL_W-1:0] tol);
        logic [63:0] num;
        logic [63:0] one;
        logic [63:0] prev_est;
        logic [63:0] est;
        logic [63:0] quot;
        logic [63:0] gap;
        int unsigned steps;
        logic        running;
        sqrt_word_t  w;
        begin
            one      = 64'd1 << FRAC_BITS;
            num      = 64'(x) << FRAC_BITS;
            prev_est = '0;
            est      = (64'(x) < one) ? one : 64'(x);
            steps    = 0;
            running  = 1'b1;
            w.cap    = 1'b0;
            while (running)
            begin
                gap = (est >= prev_est) ? est - prev_est : prev_est - est;
                if (gap <= 64'(tol))
                    running = 1'b0;
                else if (steps >= MAX_ITERATIONS)
                begin
                    w.cap   = 1'b1;
                    running = 1'b0;
                end
                else
                begin
                    prev_est = est;
                    quot     = (prev_est != 0) ? num / prev_est : '0;
                    est      = (prev_est + quot) >> 1;
                    steps++;
                end
            end
            w.root  = (est > 64'(ROOT_MAX)) ? ROOT_MAX : est[ROOT_W-1:0];
            w.iters = (steps > COUNT_MAX) ? COUNT_MAX : steps[COUNT_W-1:0];
            return w;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [X_W-1:0] x,
                                   input logic [63:0] want, input logic [63:0] got);
        begin
            $display("mismatch on %s (x=%08h): expected %0d, got %0d", what, x, want, got);
            mismatch_count++;
        end
    endtask

    // Compare one accepted result word against the oldest expectation.
    task automatic check_result();
        pending_t p;
        begin
            if (pending_roots.size() == 0)
                report_mismatch("word with nothing expected", '0, 64'd0, 64'(root));
            else
            begin
                p = pending_roots.pop_front();
                if (root !== p.want.root)
                    report_mismatch("root", p.x, 64'(p.want.root), 64'(root));
                if (iterations_used !== p.want.iters)
                    report_mismatch("iterations_used", p.x, 64'(p.want.iters),
                                    64'(iterations_used));
                if (cap_reached !== p.want.cap)
                    report_mismatch("cap_reached", p.x, 64'(p.want.cap), 64'(cap_reached));
            end
        end
    endtask

    // Result side: check on each handshake, then stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_result();
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one operand and hold it until taken. Insert a random gap first;
    // when there is none, keep valid high straight on from the last word.
    task automatic send_word(input logic [X_W-1:0] x, input logic known,
                             input sqrt_word_t want);
        pending_t p;
        begin
            if ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < send_idle_pct)
                    @(posedge clk);
            end
            in_valid <= 1'b1;
            x_value  <= x;
            do
                @(posedge clk);
            while (!in_ready);
            p.x    = x;
            p.want = known ? want : predict_sqrt(x, tol_shadow);
            pending_roots.push_back(p);
        end
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic wait_for_results();
        begin
            in_valid <= 1'b0;
            while (pending_roots.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= addr;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            data    = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Set the tolerance with the core idle, then read it back. Only the
    // low 16 bits of the written word are kept.
    task automatic set_tolerance(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        begin
            wait_for_results();
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= TOL_ADDR;
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            tol_raw    = value;
            tol_shadow = value[TOL_W-1:0];
            @(posedge clk);
            apb_read(TOL_ADDR, readback);
            if (readback !== DATA_W'(tol_shadow))
                report_mismatch("tolerance readback", '0, 64'(tol_shadow), 64'(readback));
        end
    endtask

    task automatic add_case(input logic [DATA_W-1:0] tol_write, input logic [X_W-1:0] x,
                            input logic known, input logic [ROOT_W-1:0] want_root,
                            input logic [COUNT_W-1:0] want_iters, input logic want_cap);
        sqrt_case_t c;
        begin
            c.tol_write  = tol_write;
            c.x          = x;
            c.known      = known;
            c.want.root  = want_root;
            c.want.iters = want_iters;
            c.want.cap   = want_cap;
            sqrt_cases.push_back(c);
        end
    endtask

    // Mix full-range operands with small ones, spread magnitudes, perfect
    // squares and their neighbors, and the field extremes.
    function automatic logic [X_W-1:0] pick_operand();
        logic [X_W-1:0] s;
        begin
            case ($urandom_range(7))
                0, 1, 2: return $urandom;
                3:       return $urandom_range(65535);
                4:       return $urandom >> $urandom_range(31);
                5:
                begin
                    s = $urandom_range(65535);
                    return s * s;
                end
                6:
                begin
                    s = $urandom_range(1, 65535);
                    return $urandom_range(1) ? s * s - 1 : s * s + 1;
                end
                default:
                    case ($urandom_range(4))
                        0:       return '0;
                        1:       return 32'd1;
                        2:       return 32'h0000_FFFF;
                        3:       return 32'h0001_0000;
                        default: return '1;
                    endcase
            endcase
        end
    endfunction

    initial
    begin : stimulus
        logic [DATA_W-1:0] readback;
        logic [TOL_W-1:0]  seg_tol;
        sqrt_word_t        none;
        none = '0;

        // Hold reset low from time zero, then release it for good.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Check the tolerance comes out of reset at its default.
        apb_read(TOL_ADDR, readback);
        if (readback !== DATA_W'(TOL_RESET))
            report_mismatch("tolerance after reset", '0, 64'(TOL_RESET), 64'(readback));

        // Directed table: tolerance word, operand, and the result where it
        // is plain to see.
        // zero operand: estimate halves from 1.0 down to 1
        add_case(32'd1, 32'h0000_0000, 1'b1, 25'd1, 6'd16, 1'b0);
        // exactly 1.0 settles after one step
        add_case(32'd1, 32'h0001_0000, 1'b1, 25'h1_0000, 6'd1, 1'b0);
        add_case(32'd1, 32'h0000_0001, 1'b0, '0, '0, 1'b0);
        add_case(32'd1, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        add_case(32'd1, 32'h8000_0000, 1'b0, '0, '0, 1'b0);
        add_case(32'd1, 32'h0000_FFFF, 1'b0, '0, '0, 1'b0);
        add_case(32'd1, 32'h0001_0001, 1'b0, '0, '0, 1'b0);
        add_case(32'd1, 32'h0004_0000, 1'b0, '0, '0, 1'b0);
        add_case(32'd1, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0);
        // zero tolerance on zero operand: runs into the zero divisor
        add_case(32'd0, 32'h0000_0000, 1'b1, 25'd0, 6'd18, 1'b0);
        // zero tolerance, estimate swings between two values: hits the cap
        add_case(32'd0, 32'h0000_FFFE, 1'b1, 25'h0_FFFE, 6'd32, 1'b1);
        add_case(32'd0, 32'h0001_0002, 1'b0, '0, '0, 1'b0);
        add_case(32'd0, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        add_case(32'd0, 32'h0000_0001, 1'b0, '0, '0, 1'b0);
        add_case(32'd0, 32'h0001_0000, 1'b1, 25'h1_0000, 6'd1, 1'b0);
        // widest tolerance stops after the first halving
        add_case(32'd65535, 32'h0000_0000, 1'b1, 25'h0_8000, 6'd1, 1'b0);
        add_case(32'd65535, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        add_case(32'd65535, 32'h0001_0000, 1'b1, 25'h1_0000, 6'd1, 1'b0);
        // upper bits of the written word must be dropped
        add_case(32'h5A5A_0002, 32'h0009_0000, 1'b0, '0, '0, 1'b0);
        add_case(32'hA5A5_0000, 32'h0000_0000, 1'b1, 25'd0, 6'd18, 1'b0);
        add_case(32'h0000_8000, 32'h1234_5678, 1'b0, '0, '0, 1'b0);
        add_case(32'h0000_0100, 32'hDEAD_BEEF, 1'b0, '0, '0, 1'b0);

        send_idle_pct = 23;
        recv_idle_pct = 87;
        foreach (sqrt_cases[i])
        begin
            if (sqrt_cases[i].tol_write !== tol_raw)
                set_tolerance(sqrt_cases[i].tol_write);
            send_word(sqrt_cases[i].x, sqrt_cases[i].known, sqrt_cases[i].want);
        end

        // Random segments: new tolerance each time, idle pattern in pairs.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       seg_tol = TOL_W'($urandom_range(1, 16));
                1:       seg_tol = '0;
                2:       seg_tol = '1;
                3:       seg_tol = TOL_W'($urandom_range(65535));
                4:       seg_tol = TOL_W'($urandom_range(1, 255));
                default: seg_tol = TOL_W'(1);
            endcase
            if (seg < 2)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 87;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_tolerance({16'($urandom), seg_tol});
            for (int n = 0; n < SEGMENT_WORDS; n++)
            begin
                // Now and then, pause the sender until the core has drained.
                if ($urandom_range(63) == 0)
                    wait_for_results();
                send_word(pick_operand(), 1'b0, none);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
